FILE: src/rlew_pkg.sv
// Shared types and constants for the run-length image to display writer.
`timescale 1ns / 1ps

package rlew_pkg;

	localparam int DataW = 8;

	// Configuration register indexes.
	localparam logic [1:0] CfgOriginX  = 2'd0;
	localparam logic [1:0] CfgOriginY  = 2'd1;
	localparam logic [1:0] CfgRowWidth = 2'd2;

	// Headers above this value announce a packed run.
	localparam logic [DataW-1:0] PackedBias = 8'd127;

	localparam int JobqDepth  = 2;
	localparam int JobqPtrW   = $clog2(JobqDepth);
	localparam int JobqCountW = $clog2(JobqDepth + 1);

	// One unit of work for the back end: write data count times. A zero count
	// only carries the end-of-image clear.
	typedef struct packed {
		logic [DataW-1:0] data;
		logic [DataW-1:0] count;
		logic             eoi;
	} job_t;

	typedef struct packed {
		logic [DataW-1:0] first_data;
		logic             first_move;
		logic [DataW-1:0] first_row;
		logic             second_valid;
		logic [DataW-1:0] second_data;
		logic             second_move;
		logic [DataW-1:0] second_row;
		logic             last_of_run;
	} result_t;

endpackage

FILE: src/rle_image_to_lcd_writer.sv
// Top level of the run-length image decoder that feeds display data writes.
//
//   channel   direction  handshake          payload
//   input     in         push / full        code_byte, end_of_image
//   result    out        empty / pop        first_*, second_*, last_of_run
//   config    in         cfg_valid / ready  cfg_index, cfg_data
//
// Input bytes stall while the job queue is full; a literal byte gives one result.
// A run of n bytes gives ceil(n/2) results, one per cycle while they are popped.
// A two-entry job queue lets the parser take header bytes while the writer expands.
// The writer stalls only on a held result; nothing waits on a clearing pass.
// Reset clears all control state; the registers return to their reset values.
`timescale 1ns / 1ps

module rle_image_to_lcd_writer
	import rlew_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [DataW-1:0] code_byte,
	input  logic             end_of_image,
	output logic             empty,
	input  logic             pop,
	output logic [DataW-1:0] first_data,
	output logic             first_move,
	output logic [DataW-1:0] first_row,
	output logic             second_valid,
	output logic [DataW-1:0] second_data,
	output logic             second_move,
	output logic [DataW-1:0] second_row,
	output logic             last_of_run,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [DataW-1:0] cfg_data
);

	// The origin column is applied by the display side of each move, so only
	// the row origin and the row width are kept here.
	logic [DataW-1:0] origin_y_q;
	logic [DataW-1:0] row_width_q;

	logic    q_full;
	logic    job_push;
	job_t    push_job;
	logic    head_valid;
	job_t    head;
	logic    job_pop;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_y_q  <= '0;
			row_width_q <= 8'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CfgOriginY:  origin_y_q  <= cfg_data;
				CfgRowWidth: row_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rlew_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.code_byte    (code_byte),
		.end_of_image (end_of_image),
		.q_full       (q_full),
		.full         (full),
		.job_push     (job_push),
		.job          (push_job)
	);

	rlew_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (job_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	rlew_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.origin_y  (origin_y_q),
		.row_width (row_width_q),
		.job_valid (head_valid),
		.job       (head),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign first_data   = res.first_data;
	assign first_move   = res.first_move;
	assign first_row    = res.first_row;
	assign second_valid = res.second_valid;
	assign second_data  = res.second_data;
	assign second_move  = res.second_move;
	assign second_row   = res.second_row;
	assign last_of_run  = res.last_of_run;

endmodule

FILE: src/rlew_front.sv
// Front end: parses header, run and literal bytes into jobs.
`timescale 1ns / 1ps

module rlew_front
	import rlew_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [DataW-1:0] code_byte,
	input  logic             end_of_image,
	input  logic             q_full,
	output logic             full,
	output logic             job_push,
	output job_t             job
);

	localparam logic [1:0] PhHeader  = 2'd0;
	localparam logic [1:0] PhPacked  = 2'd1;
	localparam logic [1:0] PhLiteral = 2'd2;

	logic [1:0]       phase_q, phase_d;
	logic [DataW-1:0] left_q, left_d;
	logic             accept;
	logic             make_job;
	logic [DataW-1:0] job_count;

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		make_job  = 1'b0;
		job_count = '0;
		case (phase_q)
			PhHeader: begin
				if (code_byte > PackedBias) begin
					left_d  = code_byte - PackedBias;
					phase_d = PhPacked;
				end else begin
					left_d  = code_byte + 8'd1;
					phase_d = PhLiteral;
				end
			end
			PhPacked: begin
				make_job  = 1'b1;
				job_count = left_q;
				left_d    = '0;
				phase_d   = PhHeader;
			end
			PhLiteral: begin
				make_job  = 1'b1;
				job_count = 8'd1;
				if (left_q != '0) begin
					left_d = left_q - 8'd1;
				end
				if (left_q <= 8'd1) begin
					phase_d = PhHeader;
				end
			end
			default: begin
				phase_d = PhHeader;
				left_d  = '0;
			end
		endcase
		// A byte that ends the image still has to clear the back end.
		if (end_of_image) begin
			make_job = 1'b1;
			phase_d  = PhHeader;
			left_d   = '0;
		end
	end

	assign job_push  = accept && make_job;
	assign job.data  = code_byte;
	assign job.count = job_count;
	assign job.eoi   = end_of_image;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhHeader;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

FILE: src/rlew_jobq.sv
// Short job queue between the parser and the writer.
`timescale 1ns / 1ps

module rlew_jobq
	import rlew_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head
);

	job_t                  mem_q [JobqDepth];
	logic [JobqPtrW-1:0]   wr_ptr_q;
	logic [JobqPtrW-1:0]   rd_ptr_q;
	logic [JobqCountW-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full       = count_q == JobqCountW'(JobqDepth);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + JobqPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + JobqPtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + JobqCountW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - JobqCountW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= JobqCountW'(JobqDepth))
		else $error("job queue count beyond its depth");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("parser pushed a job into a full queue");

endmodule

FILE: src/rlew_back.sv
// Back end: expands jobs into byte pairs with cursor moves and holds the result.
`timescale 1ns / 1ps

module rlew_back
	import rlew_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DataW-1:0] origin_y,
	input  logic [DataW-1:0] row_width,
	input  logic             job_valid,
	input  job_t             job,
	output logic             job_pop,
	input  logic             pop,
	output logic             empty,
	output result_t          res
);

	logic [DataW-1:0] done_q;
	logic [DataW-1:0] column_q;
	logic [DataW-1:0] row_q;
	logic             move_q;
	logic             out_valid_q;
	result_t          res_q;

	logic [DataW-1:0] remaining;
	logic             has_bytes;
	logic             can_emit;
	logic             two;
	logic             last;

	logic [DataW-1:0] col1, col_a, col2, col_b;
	logic             wrap1, wrap2;
	logic [DataW-1:0] row_a, row_b;
	result_t          res_d;

	assign remaining = job.count - done_q;
	assign has_bytes = job.count != '0;
	assign can_emit  = job_valid && has_bytes && (!out_valid_q || pop);
	assign two       = remaining >= 8'd2;
	assign last      = remaining <= 8'd2;
	assign job_pop   = job_valid && (!has_bytes || (can_emit && last));

	// Two column steps in one cycle; the second sees the first one's wrap.
	always_comb begin
		col1  = column_q + 8'd1;
		wrap1 = col1 >= row_width;
		col_a = wrap1 ? '0 : col1;
		row_a = row_q + (wrap1 ? 8'd1 : 8'd0);
		col2  = col_a + 8'd1;
		wrap2 = col2 >= row_width;
		col_b = wrap2 ? '0 : col2;
		row_b = row_a + (wrap2 ? 8'd1 : 8'd0);

		res_d.first_data   = job.data;
		res_d.first_move   = move_q;
		res_d.first_row    = move_q ? origin_y + row_q : '0;
		res_d.second_valid = two;
		res_d.second_data  = two ? job.data : '0;
		res_d.second_move  = two && wrap1;
		res_d.second_row   = (two && wrap1) ? origin_y + row_a : '0;
		res_d.last_of_run  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			column_q    <= '0;
			row_q       <= '0;
			move_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (can_emit) begin
				done_q <= last ? '0 : done_q + 8'd2;
				if (two) begin
					column_q <= col_b;
					row_q    <= row_b;
					move_q   <= wrap2;
				end else begin
					column_q <= col_a;
					row_q    <= row_a;
					move_q   <= wrap1;
				end
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			// End of image: the cursor returns to the origin and a move is made pending.
			if (job_pop && job.eoi) begin
				column_q <= '0;
				row_q    <= '0;
				move_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_emit) begin
			res_q <= res_d;
		end
	end

	assign empty = !out_valid_q;
	assign res   = res_q;

	a_done_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && has_bytes |-> done_q < job.count)
		else $error("byte progress passed the job's count");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop && job.eoi |=> column_q == '0 && row_q == '0 && move_q)
		else $error("end of image did not clear the cursor state");

endmodule
